// ===== rtl/core/kpd_pkg.sv =====
// Shared types, constants and lookup functions for the keypad scan block.
`default_nettype none

package kpd_pkg;

  // Matrix geometry; only the first 16 key positions exist.
  localparam int unsigned KpRows = 4;
  localparam int unsigned KpCols = 4;
  localparam int unsigned KpKeys = (KpRows * KpCols < 16) ? KpRows * KpCols : 16;

  // Configuration register indexes.
  localparam logic [1:0] CfgDebounce = 2'd0;
  localparam logic [1:0] CfgDelay    = 2'd1;
  localparam logic [1:0] CfgRate     = 2'd2;
  localparam logic [1:0] CfgWindow   = 2'd3;

  // Press phase codes.
  localparam logic [1:0] PhReleased = 2'd0;
  localparam logic [1:0] PhPressed  = 2'd1;
  localparam logic [1:0] PhHeld     = 2'd2;

  typedef struct packed {
    logic [15:0] key_matrix;
    logic [31:0] now_ms;
  } kpd_in_t;

  typedef struct packed {
    logic [4:0] key_index;
    logic [7:0] key_char;
  } kpd_out_t;

  // Lowest pressed key position gives index position + 1, or 0 for none.
  function automatic logic [4:0] kpd_encode(input logic [15:0] matrix);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = KpKeys - 1; i >= 0; i--) begin
      if (matrix[i]) begin
        idx = 5'(i + 1);
      end
    end
    return idx;
  endfunction

  function automatic logic [7:0] kpd_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd1:    ch = "D";
      5'd2:    ch = "#";
      5'd3:    ch = "0";
      5'd4:    ch = "*";
      5'd5:    ch = "C";
      5'd6:    ch = "9";
      5'd7:    ch = "8";
      5'd8:    ch = "7";
      5'd9:    ch = "B";
      5'd10:   ch = "6";
      5'd11:   ch = "5";
      5'd12:   ch = "4";
      5'd13:   ch = "A";
      5'd14:   ch = "3";
      5'd15:   ch = "2";
      5'd16:   ch = "1";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kpd_rem_unit.sv =====
// Bit-serial restoring remainder unit: 32-bit dividend modulo 16-bit divisor.
`default_nettype none

module kpd_rem_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [15:0]      rem_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [15:0] div_q, div_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] trial;
  logic [16:0] diff;

  // One shift, compare and subtract step per cycle.
  assign trial = {rem_q, num_q[31]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = 16'd0;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? diff[15:0] : trial[15:0];
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/keypad_scan_debounce_repeat_unit.sv =====
// Top level of the keypad scanner: debounce, press phase tracking and auto-repeat.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    kpd_in_t  (key_matrix, now_ms)
// out       output     out_valid_o / out_ready_i  kpd_out_t (key_index, key_char)
// cfg       input      cfg_we_i, cfg_idx_i        cfg_wdata_i (16 bits)
//
// Every input beat yields exactly one output beat. A poll outside the held
// phase passes the evaluate and output states; a held poll also passes the
// hold state and, past the repeat delay, the compare state, before which the
// 32-step serial remainder unit runs when the rate is not zero. The input is
// taken only in the idle state, entered as the previous result is registered.
// A result waits in the output register while the next poll is worked on; a
// second one stalls the sequencer until the first beat leaves. Reset restores
// the register defaults and clears the debounce and phase state.

module keypad_scan_debounce_repeat_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kpd_pkg::kpd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output kpd_pkg::kpd_out_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i
);
  import kpd_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEval = 3'd1;
  localparam logic [2:0] StHold = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StCmp  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  state_q, state_d;

  // Configuration registers.
  logic [3:0]  db_polls_q;
  logic [15:0] delay_q;
  logic [15:0] rate_q;
  logic [15:0] window_q;

  // Debounce and phase state.
  logic [4:0]  prev_scan_q, prev_scan_d;
  logic [3:0]  stable_cnt_q, stable_cnt_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] start_ms_q, start_ms_d;

  // Per-poll working registers.
  logic [15:0] matrix_q, matrix_d;
  logic [31:0] now_q, now_d;
  logic [4:0]  cur_q, cur_d;
  logic [31:0] hold_q, hold_d;
  logic [31:0] over_q, over_d;
  logic [4:0]  report_q, report_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  kpd_out_t    out_data_q, out_data_d;

  // Remainder unit.
  logic        div_start;
  logic        div_done;
  logic [15:0] div_rem;

  logic [4:0]  cur;
  logic [31:0] rem_sel;

  assign in_ready_o = (state_q == StIdle);
  assign cur        = kpd_encode(matrix_q);

  // With a zero rate the remainder is taken as the dividend itself.
  assign rem_sel = (rate_q == 16'd0) ? over_q : {16'd0, div_rem};

  always_comb begin
    state_d      = state_q;
    prev_scan_d  = prev_scan_q;
    stable_cnt_d = stable_cnt_q;
    phase_d      = phase_q;
    start_ms_d   = start_ms_q;
    matrix_d     = matrix_q;
    now_d        = now_q;
    cur_d        = cur_q;
    hold_d       = hold_q;
    over_d       = over_q;
    report_d     = report_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_data_d   = out_data_q;
    div_start    = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          matrix_d = in_data_i.key_matrix;
          now_d    = in_data_i.now_ms;
          state_d  = StEval;
        end
      end

      StEval: begin
        // Debounce: count equal scans, saturating at the configured count.
        if (cur == prev_scan_q) begin
          if (stable_cnt_q < db_polls_q) begin
            stable_cnt_d = stable_cnt_q + 4'd1;
          end
        end else begin
          stable_cnt_d = 4'd0;
          prev_scan_d  = cur;
        end
        cur_d    = cur;
        hold_d   = now_q - start_ms_q;
        report_d = 5'd0;
        state_d  = StOut;
        if (stable_cnt_d >= db_polls_q) begin
          if (cur != 5'd0) begin
            case (phase_q)
              PhReleased: begin
                phase_d    = PhPressed;
                start_ms_d = now_q;
                report_d   = cur;
              end
              PhPressed: begin
                phase_d = PhHeld;
              end
              PhHeld: begin
                state_d = StHold;
              end
              default: begin
              end
            endcase
          end else begin
            phase_d = PhReleased;
          end
        end
      end

      StHold: begin
        // Repeat only once the hold time has passed the delay.
        if (hold_q > {16'd0, delay_q}) begin
          over_d = hold_q - {16'd0, delay_q};
          if (rate_q == 16'd0) begin
            state_d = StCmp;
          end else begin
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end else begin
          state_d = StOut;
        end
      end

      StDiv: begin
        if (div_done) begin
          state_d = StCmp;
        end
      end

      StCmp: begin
        report_d = (rem_sel < {16'd0, window_q}) ? cur_q : 5'd0;
        state_d  = StOut;
      end

      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_data_d.key_index = report_q;
          out_data_d.key_char  = kpd_char(report_q);
          state_d              = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  kpd_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (over_d),
    .divisor_i  (rate_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // The user must send configuration writes only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_polls_q <= 4'd1;
      delay_q    <= 16'd500;
      rate_q     <= 16'd100;
      window_q   <= 16'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDebounce: db_polls_q <= cfg_wdata_i[3:0];
        CfgDelay:    delay_q    <= cfg_wdata_i;
        CfgRate:     rate_q     <= cfg_wdata_i;
        CfgWindow:   window_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      prev_scan_q  <= 5'd0;
      stable_cnt_q <= 4'd0;
      phase_q      <= PhReleased;
      start_ms_q   <= 32'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_scan_q  <= prev_scan_d;
      stable_cnt_q <= stable_cnt_d;
      phase_q      <= phase_d;
      start_ms_q   <= start_ms_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matrix_q   <= matrix_d;
    now_q      <= now_d;
    cur_q      <= cur_d;
    hold_q     <= hold_d;
    over_q     <= over_d;
    report_q   <= report_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the keypad scanner: random polls, debounce and auto-repeat checks.
`timescale 1ns / 100ps

module tb;
  import kpd_pkg::*;

  // Characters of the 16 key positions, position 1 in the leftmost byte.
  localparam logic [8*16-1:0] KEYCAPS = "D#0*C987B654A321";
  // Generous cycle budget; a correct run needs only a small fraction of it.
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  kpd_in_t     in_data = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  kpd_out_t    out_data_o;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CfgDebounce;
  logic [15:0] cfg_wdata = '0;

  keypad_scan_debounce_repeat_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Our own copy of the scanner's registers and state, starting from the reset values.
  logic [3:0]  cfg_debounce = 4'd1;
  logic [15:0] cfg_delay = 16'd500;
  logic [15:0] cfg_rate = 16'd100;
  logic [15:0] cfg_window = 16'd20;
  logic [4:0]  last_scan = 5'd0;
  logic [3:0]  stable_polls = 4'd0;
  logic [1:0]  phase = PhReleased;
  logic [31:0] pressed_at = 32'd0;

  kpd_in_t  poll_q[$];          // polls waiting to be driven
  kpd_out_t key_reports_q[$];   // expected report for every accepted poll
  int       polls_queued = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       cycles = 0;
  logic     in_taken = 1'b0;
  logic     calm = 1'b0;        // set for the last part of the run: no idling at all
  int       send_gap = 0;
  int       stall_left = 0;
  logic [31:0] tick_ms;         // running millisecond base for well-formed press sequences

  // Works out the report of one poll and advances the predicted scanner state.
  function automatic kpd_out_t poll_keypad(input kpd_in_t poll);
    logic [4:0]  scan;
    logic [4:0]  hit;
    logic [31:0] hold;
    logic [31:0] over;
    logic [31:0] remainder;
    kpd_out_t    res;
    // The lowest set bit wins: rows first, then columns within the row.
    scan = 5'd0;
    for (int b = 0; b < 16; b++) begin
      if (scan == 5'd0 && poll.key_matrix[b]) begin
        scan = 5'(b + 1);
      end
    end
    // Saturating count of equal scans; a change restarts it.
    if (scan == last_scan) begin
      if (stable_polls < cfg_debounce) begin
        stable_polls = stable_polls + 4'd1;
      end
    end else begin
      stable_polls = 4'd0;
      last_scan = scan;
    end
    hit = 5'd0;
    if (stable_polls >= cfg_debounce) begin
      if (scan == 5'd0) begin
        phase = PhReleased;
      end else begin
        case (phase)
          PhReleased: begin
            phase = PhPressed;
            pressed_at = poll.now_ms;
            hit = scan;
          end
          PhPressed: begin
            phase = PhHeld;
          end
          PhHeld: begin
            // Hold time wraps modulo 2^32; a zero rate leaves the excess as it is.
            hold = poll.now_ms - pressed_at;
            if (hold > {16'd0, cfg_delay}) begin
              over = hold - {16'd0, cfg_delay};
              remainder = (cfg_rate != 16'd0) ? over % {16'd0, cfg_rate} : over;
              if (remainder < {16'd0, cfg_window}) begin
                hit = scan;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    res.key_index = hit;
    res.key_char = (hit == 5'd0) ? 8'd0 : KEYCAPS[8 * (16 - int'(hit)) +: 8];
    return res;
  endfunction

  // Register writes, accepted polls and output beats are all seen at the rising edge.
  // The predictor therefore always runs with the settings that the block holds.
  always @(posedge clk_i) begin
    kpd_out_t want;
    cycles <= cycles + 1;
    if (cfg_we) begin
      case (cfg_idx)
        CfgDebounce: begin
          cfg_debounce = cfg_wdata[3:0];
        end
        CfgDelay: begin
          cfg_delay = cfg_wdata;
        end
        CfgRate: begin
          cfg_rate = cfg_wdata;
        end
        CfgWindow: begin
          cfg_window = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
    in_taken <= in_valid && in_ready_o;
    if (in_valid && in_ready_o) begin
      key_reports_q.push_back(poll_keypad(in_data));
    end
    if (out_valid_o && out_ready) begin
      results_seen <= results_seen + 1;
      if (key_reports_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) begin
          $display("unexpected beat: key_index %0d key_char %h", out_data_o.key_index,
                   out_data_o.key_char);
        end
      end else begin
        want = key_reports_q.pop_front();
        if (out_data_o !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch at cycle %0d: key_index exp %0d got %0d, key_char exp %h got %h",
                     cycles, want.key_index, out_data_o.key_index, want.key_char,
                     out_data_o.key_char);
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Poll driver: a beat is held until taken, and random gaps come in bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 5);
        end else if (poll_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= poll_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side stalls in random bursts, otherwise it is always ready.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 5);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_poll(input logic [15:0] matrix, input logic [31:0] now);
    kpd_in_t item;
    item.key_matrix = matrix;
    item.now_ms = now;
    poll_q.push_back(item);
    polls_queued++;
  endtask

  function automatic logic [31:0] next_tick(input int step_hi);
    tick_ms = tick_ms + 32'($urandom_range(1, step_hi));
    return tick_ms;
  endfunction

  // Mostly single keys, sometimes several at once so that priority matters.
  function automatic logic [15:0] pick_keys();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return 16'h0001 << $urandom_range(0, 15);
    end else if (r < 9) begin
      return 16'($urandom);
    end
    return 16'hFFFF;
  endfunction

  // One press: optional contact bounce, a hold with random time steps (now and then
  // switching keys mid-hold), then a release of a random number of polls.
  task automatic key_episode(input int hold_lo, input int hold_hi, input int step_hi,
                             input int rel_hi);
    logic [15:0] keys;
    int          polls;
    polls = $urandom_range(hold_lo, hold_hi);
    keys = pick_keys();
    if ($urandom_range(0, 19) == 0) begin
      tick_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
    end
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 3)) begin
        queue_poll(keys, next_tick(step_hi));
        queue_poll(16'h0000, next_tick(step_hi));
      end
    end
    for (int i = 0; i < polls; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        keys = pick_keys();
      end
      queue_poll(keys, next_tick(step_hi));
    end
    repeat ($urandom_range(1, rel_hi)) begin
      queue_poll(16'h0000, next_tick(step_hi));
    end
  endtask

  // Well-formed presses for the most part, with a share of completely random polls.
  task automatic run_phase(input int target, input int hold_lo, input int hold_hi,
                           input int step_hi, input int rel_hi);
    int start;
    start = polls_queued;
    while (polls_queued - start < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          queue_poll(16'($urandom), $urandom);
        end
      end else begin
        key_episode(hold_lo, hold_hi, step_hi, rel_hi);
      end
    end
  endtask

  // Waits until every accepted poll has produced its beat; the block is idle then.
  task automatic drain();
    while (results_seen < polls_queued) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all four registers on consecutive cycles while the block is idle.
  task automatic load_settings(input logic [15:0] deb, input logic [15:0] dly,
                               input logic [15:0] rte, input logic [15:0] win);
    cfg_we <= 1'b1;
    cfg_idx <= CfgDebounce;
    cfg_wdata <= deb;
    @(negedge clk_i);
    cfg_idx <= CfgDelay;
    cfg_wdata <= dly;
    @(negedge clk_i);
    cfg_idx <= CfgRate;
    cfg_wdata <= rte;
    @(negedge clk_i);
    cfg_idx <= CfgWindow;
    cfg_wdata <= win;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    tick_ms = $urandom;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed polls with the reset settings (debounce 1, delay 500, rate 100, window 20).
    queue_poll(16'h0000, 32'h0000_0000);
    queue_poll(16'hFFFF, 32'hFFFF_FFF0);   // all keys: first poll only arms the debounce
    queue_poll(16'hFFFF, 32'hFFFF_FFFA);   // stable: key 1 reported, press time kept
    queue_poll(16'hFFFF, 32'h0000_0000);   // goes to held across the time wrap
    queue_poll(16'hFFFF, 32'd504);         // wrapped hold of 510 ms: a repeat
    queue_poll(16'h8000, 32'd600);         // a different key while held
    queue_poll(16'h8000, 32'd612);         // that key comes only through the repeat rule
    queue_poll(16'h8000, 32'd640);
    queue_poll(16'h0000, 32'd650);
    queue_poll(16'h0000, 32'd660);         // stable release
    queue_poll(16'h0020, 32'd670);
    queue_poll(16'h0020, 32'd680);         // fresh press of a middle key
    queue_poll(16'h0020, 32'd690);
    queue_poll(16'h0020, 32'd1180);        // hold equals the delay: nothing yet
    queue_poll(16'h0020, 32'd1181);        // one past the delay: repeat
    queue_poll(16'h0020, 32'd1200);        // remainder equals the window: nothing
    queue_poll(16'h0020, 32'd1299);        // remainder just below the window
    queue_poll(16'h0000, 32'hFFFF_FFFF);
    queue_poll(16'h0000, 32'h8000_0000);
    queue_poll(16'h1000, 32'h7FFF_FFFF);
    queue_poll(16'h1000, 32'h5555_5555);
    queue_poll(16'h0000, 32'hAAAA_AAAA);
    queue_poll(16'h0000, 32'h0000_0001);
    drain();

    // Zero debounce, zero delay, zero rate and the widest window.
    load_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
    run_phase(40, 3, 10, 50, 3);
    drain();

    // Largest values everywhere; long time steps so that the delay can be passed.
    load_settings(16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(60, 20, 40, 9000, 20);
    // Leave one key held long enough to saturate the count at 15.
    repeat (20) queue_poll(16'h0400, next_tick(40));
    drain();

    // The debounce drops below the saturated count while the same key stays down.
    load_settings(16'd3, 16'd40, 16'd7, 16'd3);
    repeat (5) queue_poll(16'h0400, next_tick(20));
    run_phase(40, 5, 30, 20, 6);
    drain();

    // A rate of one makes every poll past the delay a repeat.
    load_settings(16'd2, 16'd100, 16'd1, 16'd1);
    run_phase(40, 5, 20, 30, 5);
    drain();

    // A zero window never repeats.
    load_settings(16'd1, 16'd20, 16'd30, 16'd0);
    run_phase(30, 3, 15, 20, 4);
    drain();

    // Random settings; the upper write bits of the debounce register are ignored.
    // The second round runs without any idling on either side.
    for (int round = 0; round < 2; round++) begin
      load_settings({12'($urandom), 4'($urandom_range(0, 5))}, 16'($urandom_range(0, 150)),
                    16'($urandom_range(0, 40)), 16'($urandom_range(0, 45)));
      calm = (round == 1);
      run_phase(45, 3, 25, 40, 8);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && key_reports_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
